/* sv/rbmm_pkg.sv */
package rbmm_pkg;

    // Bank geometry defaults
    localparam int REG_COUNT_DEF = 30;
    localparam int MAX_BURST_DEF = 32;

    // Write-enable mask: one bit per register, registers at or above MASK_W are read-only
    localparam int MASK_W       = 30;
    localparam int MASK_IDX_W   = $clog2(MASK_W);
    localparam logic [MASK_W-1:0] MASK_RESET = 30'h0060_0000;

    // Min/max unit register addresses
    localparam int OPERAND_A_ADDR = 21;
    localparam int OPERAND_B_ADDR = 22;
    localparam int MIN_ADDR       = 23;
    localparam int MAX_ADDR       = 24;

    localparam int OP_W   = 2;
    localparam int BYTE_W = 8;

    typedef enum logic [OP_W-1:0] {
        OP_ADDR = 2'd0,
        OP_DATA = 2'd1,
        OP_READ = 2'd2,
        OP_NONE = 2'd3
    } op_t;

    typedef enum logic [4:0] {
        ST_IDLE    = 5'b00001,
        ST_MIN     = 5'b00010,
        ST_MAX     = 5'b00100,
        ST_RD_LOAD = 5'b01000,
        ST_RD_OUT  = 5'b10000
    } state_t;

endpackage

/* sv/rbmm_bank.sv */
module rbmm_bank #(
    parameter int REG_COUNT = rbmm_pkg::REG_COUNT_DEF,
    parameter int IDX_W     = $clog2(REG_COUNT)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        wr_en,
    input  logic [IDX_W-1:0]            wr_addr,
    input  logic [rbmm_pkg::BYTE_W-1:0] wr_data,
    input  logic [IDX_W-1:0]            rd_addr,
    output logic [rbmm_pkg::BYTE_W-1:0] rd_data
);

    logic [rbmm_pkg::BYTE_W-1:0] mem_reg [REG_COUNT];
    logic [REG_COUNT-1:0]        vld_reg;
    logic [rbmm_pkg::BYTE_W-1:0] rd_data_reg;
    logic                        rd_vld_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem_reg[rd_addr];
    end

    // Entries never written read as zero
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end else begin
            if (wr_en) begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    assign rd_data = rd_vld_reg ? rd_data_reg : '0;

endmodule

/* sv/rbmm_seq.sv */
module rbmm_seq #(
    parameter int REG_COUNT = rbmm_pkg::REG_COUNT_DEF,
    parameter int MAX_BURST = rbmm_pkg::MAX_BURST_DEF,
    parameter int IDX_W     = $clog2(REG_COUNT)
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic [rbmm_pkg::MASK_W-1:0] mask,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rbmm_pkg::OP_W-1:0]   s_op,
    input  logic [rbmm_pkg::BYTE_W-1:0] s_byte_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rbmm_pkg::BYTE_W-1:0] m_read_data,
    output logic                        m_last,
    output logic                        wr_en,
    output logic [IDX_W-1:0]            wr_addr,
    output logic [rbmm_pkg::BYTE_W-1:0] wr_data,
    output logic [IDX_W-1:0]            rd_addr,
    input  logic [rbmm_pkg::BYTE_W-1:0] rd_data
);

    localparam int PTR_W = $clog2(REG_COUNT + 1);

    rbmm_pkg::state_t state_reg, state_next;
    logic [PTR_W-1:0]            ptr_reg, ptr_next;
    logic                        ptr_vld_reg, ptr_vld_next;
    logic [rbmm_pkg::BYTE_W-1:0] opa_reg, opa_next;
    logic [rbmm_pkg::BYTE_W-1:0] opb_reg, opb_next;
    logic                        gt_reg, gt_next;
    logic [PTR_W-1:0]            addr_reg, addr_next;
    logic [PTR_W-1:0]            rem_reg, rem_next;
    logic                        m_valid_reg, m_valid_next;
    logic [rbmm_pkg::BYTE_W-1:0] m_data_reg, m_data_next;
    logic                        m_last_reg, m_last_next;

    logic [PTR_W-1:0] avail;
    logic             writable;
    logic             in_range;
    logic             is_opa;
    logic             is_opb;

    assign avail    = PTR_W'(REG_COUNT) - ptr_reg;
    assign in_range = 32'(ptr_reg) < REG_COUNT;
    assign writable = (32'(ptr_reg) < rbmm_pkg::MASK_W)
                      && mask[ptr_reg[rbmm_pkg::MASK_IDX_W-1:0]];
    assign is_opa   = ptr_reg == PTR_W'(rbmm_pkg::OPERAND_A_ADDR);
    assign is_opb   = ptr_reg == PTR_W'(rbmm_pkg::OPERAND_B_ADDR);

    always_comb begin
        state_next   = state_reg;
        ptr_next     = ptr_reg;
        ptr_vld_next = ptr_vld_reg;
        opa_next     = opa_reg;
        opb_next     = opb_reg;
        gt_next      = gt_reg;
        addr_next    = addr_reg;
        rem_next     = rem_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        wr_en        = 1'b0;
        wr_addr      = ptr_reg[IDX_W-1:0];
        wr_data      = s_byte_value;

        case (state_reg)
            rbmm_pkg::ST_IDLE: begin
                if (s_valid) begin
                    case (rbmm_pkg::op_t'(s_op))
                        rbmm_pkg::OP_ADDR: begin
                            if (32'(s_byte_value) < REG_COUNT) begin
                                ptr_next     = s_byte_value[PTR_W-1:0];
                                ptr_vld_next = 1'b1;
                            end else begin
                                ptr_vld_next = 1'b0;
                            end
                        end
                        rbmm_pkg::OP_DATA: begin
                            if (ptr_vld_reg && in_range) begin
                                wr_en    = writable;
                                ptr_next = ptr_reg + PTR_W'(1);
                                if (is_opa && writable) begin
                                    opa_next = s_byte_value;
                                end
                                if (is_opb && writable) begin
                                    opb_next = s_byte_value;
                                end
                                // Operand touched: refresh min/max even on refused write
                                if (is_opa || is_opb) begin
                                    state_next = rbmm_pkg::ST_MIN;
                                end
                            end
                        end
                        rbmm_pkg::OP_READ: begin
                            if (ptr_vld_reg) begin
                                ptr_vld_next = 1'b0;
                                if (in_range) begin
                                    addr_next = ptr_reg;
                                    if (32'(avail) > MAX_BURST) begin
                                        rem_next = PTR_W'(MAX_BURST);
                                    end else begin
                                        rem_next = avail;
                                    end
                                    state_next = rbmm_pkg::ST_RD_LOAD;
                                end
                            end
                        end
                        default: begin
                        end
                    endcase
                end
            end
            rbmm_pkg::ST_MIN: begin
                gt_next    = opa_reg > opb_reg;
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(rbmm_pkg::MIN_ADDR);
                wr_data    = (opa_reg > opb_reg) ? opb_reg : opa_reg;
                state_next = rbmm_pkg::ST_MAX;
            end
            rbmm_pkg::ST_MAX: begin
                wr_en      = 1'b1;
                wr_addr    = IDX_W'(rbmm_pkg::MAX_ADDR);
                wr_data    = gt_reg ? opa_reg : opb_reg;
                state_next = rbmm_pkg::ST_IDLE;
            end
            rbmm_pkg::ST_RD_LOAD: begin
                m_valid_next = 1'b1;
                m_data_next  = rd_data;
                m_last_next  = rem_reg == PTR_W'(1);
                state_next   = rbmm_pkg::ST_RD_OUT;
            end
            rbmm_pkg::ST_RD_OUT: begin
                if (m_ready) begin
                    m_valid_next = 1'b0;
                    if (m_last_reg) begin
                        state_next = rbmm_pkg::ST_IDLE;
                    end else begin
                        addr_next  = addr_reg + PTR_W'(1);
                        rem_next   = rem_reg - PTR_W'(1);
                        state_next = rbmm_pkg::ST_RD_LOAD;
                    end
                end
            end
            default: begin
                state_next = rbmm_pkg::ST_IDLE;
            end
        endcase
    end

    // Bank read data is registered from the next address, so it lands in time for RD_LOAD
    assign rd_addr = addr_next[IDX_W-1:0];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= rbmm_pkg::ST_IDLE;
            ptr_reg     <= '0;
            ptr_vld_reg <= 1'b0;
            opa_reg     <= '0;
            opb_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            ptr_reg     <= ptr_next;
            ptr_vld_reg <= ptr_vld_next;
            opa_reg     <= opa_next;
            opb_reg     <= opb_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        gt_reg     <= gt_next;
        addr_reg   <= addr_next;
        rem_reg    <= rem_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign s_ready     = state_reg == rbmm_pkg::ST_IDLE;
    assign m_valid     = m_valid_reg;
    assign m_read_data = m_data_reg;
    assign m_last      = m_last_reg;

endmodule

/* sv/byte_register_bank_with_minmax_top.sv */
// Channel   Handshake           Payload
// s_        s_valid / s_ready   s_op[1:0], s_byte_value[7:0]
// m_        m_valid / m_ready   m_read_data[7:0], m_last
// cfg_      cfg_wr_en           cfg_wr_data[29:0] (write-enable mask)
//
// A data request that hits an operand register holds s_ready low while min and max
// are written back through the single bank write port (ST_MIN, then ST_MAX).
// A read request is accepted, then each byte passes a bank read and then the output
// register, and can be held by an m_ready stall; s_ready stays low until the last byte is taken.
// Reset is synchronous on aresetn; the bank reads as zero after it.
module byte_register_bank_with_minmax_top #(
    parameter int REG_COUNT = rbmm_pkg::REG_COUNT_DEF,
    parameter int MAX_BURST = rbmm_pkg::MAX_BURST_DEF
) (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        cfg_wr_en,
    input  logic [rbmm_pkg::MASK_W-1:0] cfg_wr_data,
    input  logic                        s_valid,
    output logic                        s_ready,
    input  logic [rbmm_pkg::OP_W-1:0]   s_op,
    input  logic [rbmm_pkg::BYTE_W-1:0] s_byte_value,
    output logic                        m_valid,
    input  logic                        m_ready,
    output logic [rbmm_pkg::BYTE_W-1:0] m_read_data,
    output logic                        m_last
);

    localparam int IDX_W = $clog2(REG_COUNT);

    logic [rbmm_pkg::MASK_W-1:0] mask_reg;
    logic                        wr_en;
    logic [IDX_W-1:0]            wr_addr;
    logic [rbmm_pkg::BYTE_W-1:0] wr_data;
    logic [IDX_W-1:0]            rd_addr;
    logic [rbmm_pkg::BYTE_W-1:0] rd_data;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_reg <= rbmm_pkg::MASK_RESET;
        end else if (cfg_wr_en) begin
            mask_reg <= cfg_wr_data;
        end
    end

    rbmm_seq #(
        .REG_COUNT (REG_COUNT),
        .MAX_BURST (MAX_BURST),
        .IDX_W     (IDX_W)
    ) u_seq (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .mask         (mask_reg),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_byte_value (s_byte_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_last       (m_last),
        .wr_en        (wr_en),
        .wr_addr      (wr_addr),
        .wr_data      (wr_data),
        .rd_addr      (rd_addr),
        .rd_data      (rd_data)
    );

    rbmm_bank #(
        .REG_COUNT (REG_COUNT),
        .IDX_W     (IDX_W)
    ) u_bank (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data (wr_data),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps

module tb_top;

    localparam int NREGS       = rbmm_pkg::REG_COUNT_DEF;
    localparam int BURST       = rbmm_pkg::MAX_BURST_DEF;
    localparam int PTR_W       = $clog2(NREGS + 1);
    localparam int IDX_W       = $clog2(NREGS);
    localparam int CYCLE_LIMIT = 400000;
    localparam int SETTLE      = 10;
    localparam int HOLD_CYCLES = 200;
    localparam int PHASES      = 6;
    localparam int PHASE_REQS  = 57;
    localparam int DIR_ROWS    = 26;

    typedef struct packed {
        logic [rbmm_pkg::BYTE_W-1:0] data;
        logic                        last;
    } rd_byte_t;

    // fixed = 1: the row carries its own expectation, cnt bytes of value fill
    typedef struct packed {
        rbmm_pkg::op_t               op;
        logic [rbmm_pkg::BYTE_W-1:0] val;
        logic                        fixed;
        logic [5:0]                  cnt;
        logic [rbmm_pkg::BYTE_W-1:0] fill;
    } dir_row_t;

    logic                        aclk = 1'b0;
    logic                        aresetn;
    logic                        cfg_wr_en;
    logic [rbmm_pkg::MASK_W-1:0] cfg_wr_data;
    logic                        s_valid;
    logic                        s_ready;
    logic [rbmm_pkg::OP_W-1:0]   s_op;
    logic [rbmm_pkg::BYTE_W-1:0] s_byte_value;
    logic                        m_valid;
    logic                        m_ready;
    logic [rbmm_pkg::BYTE_W-1:0] m_read_data;
    logic                        m_last;

    rd_byte_t                    rd_expect_q[$];
    logic [rbmm_pkg::BYTE_W-1:0] bank_m [NREGS];
    logic [PTR_W-1:0]            ptr_m;
    logic                        ptr_ok_m;
    logic [rbmm_pkg::MASK_W-1:0] mask_m;

    int errors    = 0;
    int rx_count  = 0;
    int cycles    = 0;
    int req_count = 0;
    bit calm      = 1'b0;

    dir_row_t dir_tab [DIR_ROWS] = '{
        '{rbmm_pkg::OP_READ, 8'h00, 1'b1, 6'd0,  8'h00},  // pointer invalid after reset
        '{rbmm_pkg::OP_ADDR, 8'h00, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_READ, 8'hFF, 1'b1, 6'd30, 8'h00},  // whole bank, all zero
        '{rbmm_pkg::OP_ADDR, 8'h00, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_DATA, 8'hA5, 1'b0, 6'd0,  8'h00},  // register 0 not writable
        '{rbmm_pkg::OP_ADDR, 8'h15, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_DATA, 8'hFF, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_DATA, 8'h00, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_ADDR, 8'h15, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_READ, 8'h00, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_ADDR, 8'h1D, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_READ, 8'h00, 1'b1, 6'd1,  8'h00},  // last register only
        '{rbmm_pkg::OP_ADDR, 8'h1D, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_DATA, 8'h12, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_DATA, 8'h34, 1'b0, 6'd0,  8'h00},  // past the end
        '{rbmm_pkg::OP_READ, 8'h00, 1'b1, 6'd0,  8'h00},  // read at the end
        '{rbmm_pkg::OP_ADDR, 8'h1E, 1'b0, 6'd0,  8'h00},  // first out-of-range address
        '{rbmm_pkg::OP_DATA, 8'h77, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_READ, 8'h00, 1'b1, 6'd0,  8'h00},
        '{rbmm_pkg::OP_ADDR, 8'hFF, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_NONE, 8'hAA, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_ADDR, 8'h15, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_DATA, 8'h80, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_DATA, 8'h80, 1'b0, 6'd0,  8'h00},  // equal operands
        '{rbmm_pkg::OP_ADDR, 8'h14, 1'b0, 6'd0,  8'h00},
        '{rbmm_pkg::OP_READ, 8'h00, 1'b0, 6'd0,  8'h00}
    };

    byte_register_bank_with_minmax_top uut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_wr_data  (cfg_wr_data),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_op         (s_op),
        .s_byte_value (s_byte_value),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_read_data  (m_read_data),
        .m_last       (m_last)
    );

    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        $display("mismatch %s: got %0h expected %0h (cycle %0d)", what, got, want, cycles);
        errors++;
    endtask

    // Bank model: update state for one request, queue the bytes a read sends back
    task automatic model_request(input rbmm_pkg::op_t op,
                                 input logic [rbmm_pkg::BYTE_W-1:0] val,
                                 input bit to_queue);
        int start;
        int n;
        int k;
        logic [rbmm_pkg::BYTE_W-1:0] a;
        logic [rbmm_pkg::BYTE_W-1:0] b;
        case (op)
            rbmm_pkg::OP_ADDR: begin
                if (int'(val) < NREGS) begin
                    ptr_m    = val[PTR_W-1:0];
                    ptr_ok_m = 1'b1;
                end else begin
                    ptr_ok_m = 1'b0;
                end
            end
            rbmm_pkg::OP_DATA: begin
                if (ptr_ok_m && int'(ptr_m) < NREGS) begin
                    if (int'(ptr_m) < rbmm_pkg::MASK_W
                        && mask_m[ptr_m[rbmm_pkg::MASK_IDX_W-1:0]])
                        bank_m[ptr_m[IDX_W-1:0]] = val;
                    // min/max follow the operands even if the write was refused
                    if (int'(ptr_m) inside {rbmm_pkg::OPERAND_A_ADDR,
                                            rbmm_pkg::OPERAND_B_ADDR}) begin
                        a = bank_m[IDX_W'(rbmm_pkg::OPERAND_A_ADDR)];
                        b = bank_m[IDX_W'(rbmm_pkg::OPERAND_B_ADDR)];
                        bank_m[IDX_W'(rbmm_pkg::MIN_ADDR)] = (a > b) ? b : a;
                        bank_m[IDX_W'(rbmm_pkg::MAX_ADDR)] = (a > b) ? a : b;
                    end
                    ptr_m = ptr_m + PTR_W'(1);
                end
            end
            rbmm_pkg::OP_READ: begin
                if (ptr_ok_m) begin
                    start = int'(ptr_m);
                    n = (start < NREGS) ? NREGS - start : 0;
                    if (n > BURST)
                        n = BURST;
                    if (to_queue)
                        for (k = 0; k < n; k++)
                            rd_expect_q.push_back('{data: bank_m[IDX_W'(start + k)],
                                                    last: (k == n - 1)});
                    ptr_ok_m = 1'b0;
                end
            end
            default: ;
        endcase
    endtask

    // Offer one request, hold it until accepted, then update the model
    task automatic send_req(input rbmm_pkg::op_t op, input logic [rbmm_pkg::BYTE_W-1:0] val,
                            input bit to_queue);
        while (!calm && $urandom_range(0, 99) < 21) begin
            @(negedge aclk);
            s_valid = 1'b0;
        end
        @(negedge aclk);
        s_valid      = 1'b1;
        s_op         = op;
        s_byte_value = val;
        do @(posedge aclk); while (!s_ready);
        model_request(op, val, to_queue);
        if (op != rbmm_pkg::OP_NONE)
            req_count++;
    endtask

    task automatic drain_results;
        @(negedge aclk);
        s_valid = 1'b0;
        while (rd_expect_q.size() != 0)
            @(posedge aclk);
        // let any pending operand min/max write-back finish before going on
        repeat (SETTLE) @(posedge aclk);
    endtask

    task automatic write_mask(input logic [rbmm_pkg::MASK_W-1:0] m);
        drain_results();
        @(negedge aclk);
        cfg_wr_en   = 1'b1;
        cfg_wr_data = m;
        @(negedge aclk);
        cfg_wr_en   = 1'b0;
        mask_m      = m;
    endtask

    always @(posedge aclk) begin
        rd_byte_t e;
        if (aresetn && m_valid && m_ready) begin
            rx_count++;
            if (rd_expect_q.size() == 0) begin
                report_mismatch("unexpected read byte", int'(m_read_data), 0);
            end else begin
                e = rd_expect_q.pop_front();
                if (m_read_data !== e.data)
                    report_mismatch("read_data", int'(m_read_data), int'(e.data));
                if (m_last !== e.last)
                    report_mismatch("last", int'(m_last), int'(e.last));
            end
        end
    end

    initial begin
        int  n;
        bit  held;
        held    = 1'b0;
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (aresetn && !held && rx_count >= 60 && m_valid) begin
                // hold off long enough for the input side to back up
                held    = 1'b1;
                m_ready = 1'b0;
                for (n = 1; n < HOLD_CYCLES; n++)
                    @(negedge aclk);
            end else begin
                m_ready = calm || ($urandom_range(0, 99) >= 21);
            end
        end
    end

    initial begin
        int                          ph;
        int                          i;
        int                          k;
        int                          r;
        int                          first;
        logic [rbmm_pkg::BYTE_W-1:0] addr;
        logic [rbmm_pkg::MASK_W-1:0] m;
        dir_row_t                    row;

        aresetn      = 1'b0;
        cfg_wr_en    = 1'b0;
        cfg_wr_data  = '0;
        s_valid      = 1'b0;
        s_op         = rbmm_pkg::OP_NONE;
        s_byte_value = '0;
        for (i = 0; i < NREGS; i++)
            bank_m[IDX_W'(i)] = '0;
        ptr_m    = '0;
        ptr_ok_m = 1'b0;
        mask_m   = rbmm_pkg::MASK_RESET;

        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        for (i = 0; i < DIR_ROWS; i++) begin
            row = dir_tab[i];
            send_req(row.op, row.val, !row.fixed);
            if (row.fixed)
                for (k = 0; k < int'(row.cnt); k++)
                    rd_expect_q.push_back('{data: row.fill,
                                            last: (k == int'(row.cnt) - 1)});
        end

        for (ph = 0; ph < PHASES; ph++) begin
            case (ph)
                0:       m = '1;
                1:       m = '0;
                default: m = rbmm_pkg::MASK_W'($urandom);
            endcase
            write_mask(m);
            calm  = (ph == 4);
            first = req_count;
            while (req_count - first < PHASE_REQS) begin
                r    = $urandom_range(0, 99);
                addr = rbmm_pkg::BYTE_W'($urandom_range(0, 1)
                                         ? $urandom_range(18, NREGS - 1)
                                         : $urandom_range(0, NREGS - 1));
                if (r < 45) begin
                    send_req(rbmm_pkg::OP_ADDR, addr, 1'b1);
                    k = $urandom_range(0, 6);
                    repeat (k) send_req(rbmm_pkg::OP_DATA,
                                        rbmm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
                    if ($urandom_range(0, 99) < 30)
                        send_req(rbmm_pkg::OP_READ,
                                 rbmm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
                end else if (r < 80) begin
                    send_req(rbmm_pkg::OP_ADDR, addr, 1'b1);
                    send_req(rbmm_pkg::OP_READ,
                             rbmm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
                end else if (r < 88) begin
                    send_req(rbmm_pkg::OP_ADDR,
                             rbmm_pkg::BYTE_W'($urandom_range(NREGS, 255)), 1'b1);
                end else begin
                    send_req(rbmm_pkg::op_t'(rbmm_pkg::OP_W'($urandom_range(0, 3))),
                             rbmm_pkg::BYTE_W'($urandom_range(0, 255)), 1'b1);
                end
            end
        end
        calm = 1'b0;

        drain_results();
        if (errors == 0 && rd_expect_q.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule
